>>> design/icl_pkg.sv
// Shared constants for the indexed circular list engine: operation and status codes, field widths.
package icl_pkg;

    localparam int FUNC_W   = 4;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam func_t F_ADDFIRST = 4'd0;
    localparam func_t F_ADDLAST  = 4'd1;
    localparam func_t F_ADDAT    = 4'd2;
    localparam func_t F_REMFIRST = 4'd3;
    localparam func_t F_REMLAST  = 4'd4;
    localparam func_t F_REMAT    = 4'd5;
    localparam func_t F_GETFIRST = 4'd6;
    localparam func_t F_GETLAST  = 4'd7;
    localparam func_t F_GETAT    = 4'd8;
    localparam func_t F_SIZE     = 4'd9;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_EMPTY   = 2'd1;
    localparam status_t ST_INVALID = 2'd2;
    localparam status_t ST_FULL    = 2'd3;

endpackage

>>> design/icl_req_if.sv
// Request channel: operation code, list index and value to insert.
interface icl_req_if;
    import icl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item;

    modport source (output valid, output func, output position, output item, input ready);
    modport sink   (input valid, input func, input position, input item, output ready);
endinterface

>>> design/icl_rsp_if.sv
// Response channel: value, entry count and status of one operation.
interface icl_rsp_if;
    import icl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic [COUNT_W-1:0]       count;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output value, output count, output status, input ready);
    modport sink   (input valid, input value, input count, input status, output ready);
endinterface

>>> design/icl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module icl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> design/indexed_circular_list_engine.sv
// Top level of the indexed circular list engine: slot memories and the operation sequencer.
//
//  channel | modport | per transfer
//  --------+---------+-----------------------------------------
//  req     | sink    | func, position, item
//  rsp     | source  | value, count, status
//
//  One operation at a time; req is ready only while the sequencer is idle.
//  Size, errors and unused codes go straight to the answer; add at either end, get at either
//  end and remove at the front skip the link walk; an operation at index k, remove at the
//  back included (k is count-1), walks the links from the front, one link-memory read per
//  walk step.
//  Reset is asynchronous and empties the list at once; no memory clearing pass.
//  The result register holds while rsp is stalled.
module indexed_circular_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    icl_req_if.sink     req,
    icl_rsp_if.source   rsp
);
    import icl_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef logic [SW-1:0] slot_t;
    typedef logic [CW-1:0] cnt_t;

    typedef enum logic [1:0] {K_NONE, K_INS, K_REM, K_GET} kind_t;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_WALK, S_W1, S_W2, S_RD, S_WLINK, S_WFREE, S_GETV, S_OUT
    } state_t;

    state_t                state_reg;
    kind_t                 kind_reg;
    cnt_t                  idx_reg;
    logic [DATA_W-1:0]     item_reg;
    cnt_t                  count_reg;
    cnt_t                  hwm_reg;
    slot_t                 front_reg;
    slot_t                 back_reg;
    slot_t                 free_head_reg;
    slot_t                 n_reg;
    logic                  pop_reg;
    slot_t                 t_reg;
    slot_t                 p_reg;
    slot_t                 nx_reg;
    slot_t                 cur_reg;
    cnt_t                  j_reg;
    logic [DATA_W-1:0]     value_reg;
    status_t               status_reg;

    // memory ports
    logic                  link_we;
    slot_t                 link_waddr;
    slot_t                 link_wdata;
    slot_t                 link_raddr;
    slot_t                 link_rdata;
    logic                  val_we;
    logic [DATA_W-1:0]     val_rdata;

    // decode
    kind_t                 dec_kind;
    cnt_t                  dec_idx;
    status_t               dec_status;
    logic [DATA_W-1:0]     dec_value;
    logic                  full;
    logic                  empty;
    logic [PW-1:0]         pos_w;
    logic [PW-1:0]         cnt_w;
    logic                  pop;
    slot_t                 new_slot;
    slot_t                 node_c;
    logic                  accept;

    icl_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    icl_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (n_reg),
        .wdata (item_reg),
        .raddr (t_reg),
        .rdata (val_rdata)
    );

    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign pos_w    = PW'(req.position);
    assign cnt_w    = PW'(count_reg);
    // freed slots below the high-water mark are chained through the link memory
    assign pop      = (hwm_reg != count_reg);
    assign new_slot = pop ? free_head_reg : hwm_reg[SW-1:0];
    assign node_c   = (j_reg == '0) ? cur_reg : link_rdata;
    assign accept   = req.valid && req.ready;

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = (state_reg == S_OUT);
    assign rsp.value  = value_reg;
    assign rsp.count  = COUNT_W'(count_reg);
    assign rsp.status = status_reg;

    always_comb
    begin
        dec_kind   = K_NONE;
        dec_idx    = '0;
        dec_status = ST_OK;
        dec_value  = '0;
        unique case (req.func)
            F_ADDFIRST, F_ADDLAST:
            begin
                if (full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_kind = K_INS;
                    dec_idx  = (req.func == F_ADDFIRST) ? '0 : count_reg;
                end
            end
            F_ADDAT:
            begin
                if (pos_w > cnt_w)
                begin
                    dec_status = ST_INVALID;
                end
                else if (full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_kind = K_INS;
                    dec_idx  = CW'(pos_w);
                end
            end
            F_REMFIRST, F_REMLAST, F_REMAT, F_GETFIRST, F_GETLAST, F_GETAT:
            begin
                if (empty)
                begin
                    dec_status = ST_EMPTY;
                end
                else if ((req.func == F_REMAT || req.func == F_GETAT) && pos_w >= cnt_w)
                begin
                    dec_status = ST_INVALID;
                end
                else
                begin
                    dec_kind = (req.func == F_REMFIRST || req.func == F_REMLAST ||
                                req.func == F_REMAT) ? K_REM : K_GET;
                    if (req.func == F_REMFIRST || req.func == F_GETFIRST)
                    begin
                        dec_idx = '0;
                    end
                    else if (req.func == F_REMLAST || req.func == F_GETLAST)
                    begin
                        dec_idx = count_reg - CW'(1);
                    end
                    else
                    begin
                        dec_idx = CW'(pos_w);
                    end
                end
            end
            F_SIZE:
            begin
                dec_value = DATA_W'(count_reg);
            end
            default:
            begin
                dec_kind = K_NONE;
            end
        endcase
    end

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = n_reg;
        link_wdata = t_reg;
        link_raddr = free_head_reg;
        val_we     = 1'b0;
        unique case (state_reg)
            S_START:
            begin
                val_we = (kind_reg == K_INS);
            end
            S_WALK:
            begin
                link_raddr = node_c;
            end
            S_RD:
            begin
                link_raddr = t_reg;
            end
            S_W1:
            begin
                link_we = 1'b1;
            end
            S_W2:
            begin
                link_we    = 1'b1;
                link_waddr = p_reg;
                link_wdata = n_reg;
            end
            S_WLINK:
            begin
                link_we    = 1'b1;
                link_waddr = p_reg;
                link_wdata = link_rdata;
            end
            S_WFREE:
            begin
                link_we    = 1'b1;
                link_waddr = t_reg;
                link_wdata = free_head_reg;
            end
            default:
            begin
                link_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_NONE;
            idx_reg       <= '0;
            item_reg      <= '0;
            count_reg     <= '0;
            hwm_reg       <= '0;
            front_reg     <= '0;
            back_reg      <= '0;
            free_head_reg <= '0;
            n_reg         <= '0;
            pop_reg       <= 1'b0;
            t_reg         <= '0;
            p_reg         <= '0;
            nx_reg        <= '0;
            cur_reg       <= '0;
            j_reg         <= '0;
            value_reg     <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg   <= dec_kind;
                        idx_reg    <= dec_idx;
                        item_reg   <= req.item;
                        n_reg      <= new_slot;
                        pop_reg    <= pop;
                        value_reg  <= dec_value;
                        status_reg <= dec_status;
                        state_reg  <= (dec_kind == K_NONE) ? S_OUT : S_START;
                    end
                end
                S_START:
                begin
                    cur_reg <= front_reg;
                    j_reg   <= '0;
                    unique case (kind_reg)
                        K_INS:
                        begin
                            // link memory was read at the free head on transfer
                            if (pop_reg)
                            begin
                                free_head_reg <= link_rdata;
                            end
                            if (empty)
                            begin
                                t_reg     <= n_reg;
                                p_reg     <= n_reg;
                                state_reg <= S_W1;
                            end
                            else if (idx_reg == '0 || idx_reg == count_reg)
                            begin
                                t_reg     <= front_reg;
                                p_reg     <= back_reg;
                                state_reg <= S_W1;
                            end
                            else
                            begin
                                state_reg <= S_WALK;
                            end
                        end
                        K_REM:
                        begin
                            if (idx_reg == '0)
                            begin
                                t_reg     <= front_reg;
                                p_reg     <= back_reg;
                                state_reg <= S_RD;
                            end
                            else
                            begin
                                state_reg <= S_WALK;
                            end
                        end
                        K_GET:
                        begin
                            if (idx_reg == '0)
                            begin
                                t_reg     <= front_reg;
                                state_reg <= S_RD;
                            end
                            else if (idx_reg == count_reg - CW'(1))
                            begin
                                t_reg     <= back_reg;
                                state_reg <= S_RD;
                            end
                            else
                            begin
                                state_reg <= S_WALK;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_WALK:
                begin
                    // node_c is the node at index j, cur_reg the one before it (for j > 0)
                    if (j_reg == idx_reg)
                    begin
                        t_reg     <= node_c;
                        p_reg     <= cur_reg;
                        state_reg <= (kind_reg == K_INS) ? S_W1 : S_RD;
                    end
                    else
                    begin
                        cur_reg <= node_c;
                        j_reg   <= j_reg + CW'(1);
                    end
                end
                S_W1:
                begin
                    state_reg <= S_W2;
                end
                S_W2:
                begin
                    if (idx_reg == '0)
                    begin
                        front_reg <= n_reg;
                    end
                    if (idx_reg == count_reg)
                    begin
                        back_reg <= n_reg;
                    end
                    if (!pop_reg)
                    begin
                        hwm_reg <= hwm_reg + CW'(1);
                    end
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_OUT;
                end
                S_RD:
                begin
                    state_reg <= (kind_reg == K_GET) ? S_GETV : S_WLINK;
                end
                S_GETV:
                begin
                    value_reg <= val_rdata;
                    state_reg <= S_OUT;
                end
                S_WLINK:
                begin
                    nx_reg    <= link_rdata;
                    value_reg <= val_rdata;
                    state_reg <= S_WFREE;
                end
                S_WFREE:
                begin
                    free_head_reg <= t_reg;
                    count_reg     <= count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        front_reg <= '0;
                        back_reg  <= '0;
                    end
                    else
                    begin
                        if (t_reg == front_reg)
                        begin
                            front_reg <= nx_reg;
                        end
                        if (t_reg == back_reg)
                        begin
                            back_reg <= p_reg;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CW'(CAPACITY)) && (hwm_reg >= count_reg))
        else $error("entry count out of range");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (front_reg == '0 && back_reg == '0))
        else $error("front or back not cleared on empty list");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (j_reg <= idx_reg && idx_reg < count_reg))
        else $error("link walk beyond target");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_W2) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WFREE) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("remove did not shrink the list");
`endif
endmodule

>>> verif/indexed_circular_list_engine_test.sv
// Testbench for the indexed circular list engine: directed and random list operations.
module indexed_circular_list_engine_test;
    import icl_pkg::*;

    localparam int CAP = 64;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [COUNT_W-1:0]       count;
        status_t                  status;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    icl_req_if req ();
    icl_rsp_if rsp ();

    indexed_circular_list_engine #(.CAPACITY(CAP)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #2 clk = ~clk;

    // Behavioural list: index 0 is the front.
    logic signed [DATA_W-1:0] shadow_list[$];
    answer_t pending_answers[$];
    int  errors = 0;
    int  cycles = 0;
    bit  calm = 1'b0;
    bit  sink_idle_on = 1'b1;

    function automatic answer_t predict_list_op(func_t f, logic [POS_W-1:0] p,
                                                logic signed [DATA_W-1:0] v);
        answer_t a;
        int n;
        n = shadow_list.size();
        a.value = '0;
        a.status = ST_OK;
        case (f)
            F_ADDFIRST, F_ADDLAST:
            begin
                if (n >= CAP)
                    a.status = ST_FULL;
                else if (f == F_ADDFIRST)
                    shadow_list.push_front(v);
                else
                    shadow_list.push_back(v);
            end
            F_ADDAT:
            begin
                if (p > n)
                    a.status = ST_INVALID;
                else if (n >= CAP)
                    a.status = ST_FULL;
                else
                    shadow_list.insert(p, v);
            end
            F_REMFIRST, F_REMLAST, F_REMAT:
            begin
                if (n == 0)
                    a.status = ST_EMPTY;
                else if (f == F_REMFIRST)
                    a.value = shadow_list.pop_front();
                else if (f == F_REMLAST)
                    a.value = shadow_list.pop_back();
                else if (p >= n)
                    a.status = ST_INVALID;
                else
                begin
                    a.value = shadow_list[p];
                    shadow_list.delete(p);
                end
            end
            F_GETFIRST, F_GETLAST, F_GETAT:
            begin
                if (n == 0)
                    a.status = ST_EMPTY;
                else if (f == F_GETFIRST)
                    a.value = shadow_list[0];
                else if (f == F_GETLAST)
                    a.value = shadow_list[n-1];
                else if (p >= n)
                    a.status = ST_INVALID;
                else
                    a.value = shadow_list[p];
            end
            F_SIZE:
                a.value = n;
            default: ;
        endcase
        a.count = COUNT_W'(shadow_list.size());
        return a;
    endfunction

    task automatic send_op(func_t f, logic [POS_W-1:0] p, logic signed [DATA_W-1:0] v);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.func     <= f;
        req.position <= p;
        req.item     <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_answers.push_back(predict_list_op(f, p, v));
    endtask

    // Receiver stalls in bursts.
    initial
    begin
        int stall;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                if (stall == 0)
                    rsp.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 18);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result value=%0d count=%0d status=%0d",
                         $time, rsp.value, rsp.count, rsp.status);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (rsp.value !== want.value)
                begin
                    errors++;
                    $display("%0t: value expected %0d actual %0d", $time, want.value, rsp.value);
                end
                if (rsp.count !== want.count)
                begin
                    errors++;
                    $display("%0t: count expected %0d actual %0d", $time, want.count, rsp.count);
                end
                if (rsp.status !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("indexed_circular_list_engine_test failed");
            $finish;
        end
    end

    task automatic test_empty_cases();
        send_op(F_REMFIRST, 0, 0);
        send_op(F_REMLAST, 0, 0);
        send_op(F_REMAT, 7'd127, 0);
        send_op(F_GETFIRST, 0, 0);
        send_op(F_GETLAST, 0, 0);
        send_op(F_GETAT, 0, 0);
        send_op(F_SIZE, 0, 0);
        send_op(F_ADDAT, 1, 5);
        send_op(4'd15, 7'd127, -1);
        send_op(4'd10, 0, 0);
    endtask

    task automatic test_basic_ops();
        send_op(F_ADDFIRST, 0, 32'sh7fffffff);
        send_op(F_ADDLAST, 0, 32'sh80000000);
        send_op(F_ADDAT, 1, -1);
        send_op(F_ADDAT, 0, 0);
        send_op(F_ADDAT, 4, 32'sh55aa55aa);
        send_op(F_GETAT, 2, 0);
        send_op(F_GETAT, 5, 0);
        send_op(F_GETFIRST, 0, 0);
        send_op(F_GETLAST, 0, 0);
        send_op(F_REMAT, 2, 0);
        send_op(F_REMAT, 3, 0);
        send_op(F_REMAT, 9, 0);
        send_op(F_REMAT, 0, 0);
        send_op(F_REMLAST, 0, 0);
        send_op(F_REMFIRST, 0, 0);
        send_op(F_SIZE, 0, 0);
    endtask

    task automatic test_full_list();
        repeat (CAP) send_op(F_ADDLAST, 0, $urandom);
        send_op(F_ADDFIRST, 0, 1);
        send_op(F_ADDAT, 7'd65, 1);
        send_op(F_ADDAT, 7'd64, 1);
        send_op(F_GETAT, 7'd63, 0);
        send_op(F_SIZE, 0, 0);
        repeat (CAP / 2)
            send_op(F_REMAT, POS_W'($urandom_range(0, shadow_list.size() - 1)), 0);
    endtask

    task automatic test_random_ops(int n_ops);
        func_t f;
        int len;
        logic [POS_W-1:0] p;
        repeat (n_ops)
        begin
            len = shadow_list.size();
            f = func_t'($urandom_range(0, 9));
            if ($urandom_range(0, 39) == 0)
                f = func_t'($urandom_range(10, 15));
            // Favour growth while short so indexed walks go deep.
            if (len < 20 && $urandom_range(0, 2) == 0)
                f = F_ADDAT;
            if ($urandom_range(0, 9) == 0)
                p = POS_W'($urandom);
            else
                p = POS_W'($urandom_range(0, len));
            send_op(f, p, $urandom);
        end
    endtask

    initial
    begin
        req.valid    <= 1'b0;
        req.func     <= F_SIZE;
        req.position <= '0;
        req.item     <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_cases();
        test_basic_ops();
        test_full_list();
        test_random_ops(443);
        calm = 1'b1;
        test_random_ops(80);
        req.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (CAP + 10) @(posedge clk);
        if (errors == 0 && pending_answers.size() == 0)
            $display("indexed_circular_list_engine_test passed");
        else
            $display("indexed_circular_list_engine_test failed");
        $finish;
    end
endmodule
